### rtl/b64sc_pkg.sv
// shared types, constants and alphabet functions of the base64 stream codec
package b64sc_pkg;

   localparam int GroupBytes = 3;
   localparam int GroupChars = GroupBytes + 1;

   localparam logic [7:0] PadChar    = 8'h3D;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7A;
   localparam logic [7:0] CharDigit0 = 8'h30;
   localparam logic [7:0] CharDigit9 = 8'h39;

   localparam logic [7:0] Char62Reset = 8'd43;
   localparam logic [7:0] Char63Reset = 8'd47;

   localparam int CsrAddrWidth = 4;
   localparam logic [1:0] RegDirection     = 2'd0;
   localparam logic [1:0] RegCharSixtyTwo  = 2'd1;
   localparam logic [1:0] RegCharSixtyThree = 2'd2;

   localparam logic DirEncode = 1'b0;
   localparam logic DirDecode = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       bad_char;
   } rsp_payload_type;

   typedef struct packed {
      logic       direction;
      logic [7:0] char_sixty_two;
      logic [7:0] char_sixty_three;
      logic       clear;
   } cfg_type;

   typedef struct packed {
      logic                            valid;
      logic [2:0]                      count;
      logic [GroupChars-1:0][7:0]      data;
      logic                            last;
      logic                            bad;
   } group_type;

   typedef struct packed {
      logic       is_pad;
      logic       is_bad;
      logic [5:0] value;
   } sextet_type;

   function automatic logic [7:0] sextet_to_char(input logic [5:0] v,
                                                 input logic [7:0] c62,
                                                 input logic [7:0] c63);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26) begin
         return 8'(CharUpperA + w);
      end else if (v < 6'd52) begin
         return 8'(CharLowerA + w - 8'd26);
      end else if (v < 6'd62) begin
         return 8'(CharDigit0 + w - 8'd52);
      end else if (v == 6'd62) begin
         return c62;
      end else begin
         return c63;
      end
   endfunction

   function automatic sextet_type char_to_sextet(input logic [7:0] c,
                                                 input logic [7:0] c62,
                                                 input logic [7:0] c63);
      sextet_type s;
      s = '0;
      if (c >= CharUpperA && c <= CharUpperZ) begin
         s.value = 6'(c - CharUpperA);
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
         s.value = 6'(c - CharLowerA + 8'd26);
      end else if (c >= CharDigit0 && c <= CharDigit9) begin
         s.value = 6'(c - CharDigit0 + 8'd52);
      end else if (c == c62) begin
         s.value = 6'd62;
      end else if (c == c63) begin
         s.value = 6'd63;
      end else if (c == PadChar) begin
         s.is_pad = 1'b1;
      end else begin
         s.is_bad = 1'b1;
      end
      return s;
   endfunction

endpackage

### rtl/b64sc_csr.sv
// configuration registers behind the apb-style port
module b64sc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [b64sc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   output b64sc_pkg::cfg_type                  cfg
);

   logic       direction_ff;
   logic [7:0] char62_ff;
   logic [7:0] char63_ff;
   logic       write_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= b64sc_pkg::DirEncode;
         char62_ff    <= b64sc_pkg::Char62Reset;
         char63_ff    <= b64sc_pkg::Char63Reset;
      end else if (write_en) begin
         unique case (reg_index)
            b64sc_pkg::RegDirection: begin
               direction_ff <= csr_pwdata[0];
            end
            b64sc_pkg::RegCharSixtyTwo: begin
               char62_ff <= csr_pwdata[7:0];
            end
            b64sc_pkg::RegCharSixtyThree: begin
               char63_ff <= csr_pwdata[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         b64sc_pkg::RegDirection:      csr_prdata = {31'd0, direction_ff};
         b64sc_pkg::RegCharSixtyTwo:   csr_prdata = {24'd0, char62_ff};
         b64sc_pkg::RegCharSixtyThree: csr_prdata = {24'd0, char63_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   assign cfg.direction        = direction_ff;
   assign cfg.char_sixty_two   = char62_ff;
   assign cfg.char_sixty_three = char63_ff;
   assign cfg.clear            = write_en && (reg_index == b64sc_pkg::RegDirection);

endmodule

### rtl/b64sc_group.sv
// input register and group accumulator for both directions
module b64sc_group (
   input  logic                        clock,
   input  logic                        reset,
   input  b64sc_pkg::cfg_type          cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  b64sc_pkg::req_payload_type  req_data,
   input  logic                        buf_empty,
   output b64sc_pkg::group_type        group
);

   logic                        item_valid_ff;
   b64sc_pkg::req_payload_type  item_ff;
   logic [23:0]                 bits_ff;
   logic [1:0]                  count_ff;
   logic [1:0]                  pad_ff;
   logic                        bad_ff;

   logic [23:0]                 bits_in;
   logic [1:0]                  pad_in;
   logic                        bad_in;
   logic [2:0]                  count_new;
   logic                        close;
   logic                        advance;
   b64sc_pkg::sextet_type       sx;
   logic [2:0]                  pad_sum;
   logic [1:0]                  pads;
   logic [7:0]                  b;

   always_comb begin
      b         = item_ff.in_byte;
      count_new = {1'b0, count_ff} + 3'd1;
      sx        = b64sc_pkg::char_to_sextet(b, cfg.char_sixty_two, cfg.char_sixty_three);
      pad_in    = pad_ff;
      bad_in    = bad_ff;
      bits_in   = bits_ff;
      pad_sum   = 3'd0;
      pads      = 2'd0;
      group     = '0;
      if (cfg.direction == b64sc_pkg::DirEncode) begin
         unique case (count_ff)
            2'd0:    bits_in = bits_ff | {b, 16'h0000};
            2'd1:    bits_in = bits_ff | {8'h00, b, 8'h00};
            default: bits_in = bits_ff | {16'h0000, b};
         endcase
         close = (count_new == 3'(b64sc_pkg::GroupBytes)) || item_ff.in_last;
         group.count   = 3'(b64sc_pkg::GroupChars);
         group.data[0] = b64sc_pkg::sextet_to_char(bits_in[23:18],
                            cfg.char_sixty_two, cfg.char_sixty_three);
         group.data[1] = b64sc_pkg::sextet_to_char(bits_in[17:12],
                            cfg.char_sixty_two, cfg.char_sixty_three);
         group.data[2] = (count_new >= 3'd2) ?
                         b64sc_pkg::sextet_to_char(bits_in[11:6],
                            cfg.char_sixty_two, cfg.char_sixty_three) :
                         b64sc_pkg::PadChar;
         group.data[3] = (count_new == 3'd3) ?
                         b64sc_pkg::sextet_to_char(bits_in[5:0],
                            cfg.char_sixty_two, cfg.char_sixty_three) :
                         b64sc_pkg::PadChar;
      end else begin
         if (sx.is_pad && pad_ff != 2'd3) begin
            pad_in = pad_ff + 2'd1;
         end
         bad_in = bad_ff | sx.is_bad;
         unique case (count_ff)
            2'd0: bits_in = bits_ff | {sx.value, 18'd0};
            2'd1: bits_in = bits_ff | {6'd0, sx.value, 12'd0};
            2'd2: bits_in = bits_ff | {12'd0, sx.value, 6'd0};
            2'd3: bits_in = bits_ff | {18'd0, sx.value};
         endcase
         close   = (count_new == 3'(b64sc_pkg::GroupChars)) || item_ff.in_last;
         pad_sum = {1'b0, pad_in} + (3'(b64sc_pkg::GroupChars) - count_new);
         pads    = (pad_sum > 3'd3) ? 2'd3 : pad_sum[1:0];
         group.count   = 3'(b64sc_pkg::GroupBytes) - {1'b0, pads};
         group.data[0] = bits_in[23:16];
         group.data[1] = bits_in[15:8];
         group.data[2] = bits_in[7:0];
         group.data[3] = 8'h00;
         group.bad     = bad_in;
      end
      group.last = item_ff.in_last;
      advance    = item_valid_ff && (!close || buf_empty);
      group.valid = advance && close && (group.count != 3'd0);
   end

   assign req_ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         bits_ff       <= '0;
         count_ff      <= '0;
         pad_ff        <= '0;
         bad_ff        <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         if (cfg.clear || (advance && close)) begin
            bits_ff  <= '0;
            count_ff <= '0;
            pad_ff   <= '0;
            bad_ff   <= 1'b0;
         end else if (advance) begin
            bits_ff  <= bits_in;
            count_ff <= count_new[1:0];
            pad_ff   <= pad_in;
            bad_ff   <= bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   a_group_cleared: assert property (@(posedge clock) disable iff (reset)
      advance && close |=> count_ff == 2'd0 && pad_ff == 2'd0 && !bad_ff)
      else $error("group state not cleared after a closing item");

   a_encode_count: assert property (@(posedge clock) disable iff (reset)
      cfg.direction == b64sc_pkg::DirEncode |-> count_ff != 2'd3 && pad_ff == 2'd0)
      else $error("encode group holds more than two bytes or a pad");

endmodule

### rtl/b64sc_serial.sv
// group buffer; one result item per cycle through the output register unless rsp_ready stalls
module b64sc_serial (
   input  logic                        clock,
   input  logic                        reset,
   input  b64sc_pkg::group_type        group,
   output logic                        buf_empty,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output b64sc_pkg::rsp_payload_type  rsp_data
);

   logic [b64sc_pkg::GroupChars-1:0][7:0] data_ff;
   logic [2:0]                            rem_ff;
   logic                                  last_ff;
   logic                                  bad_ff;
   logic                                  rsp_valid_ff;
   b64sc_pkg::rsp_payload_type            rsp_data_ff;
   logic                                  move;

   assign buf_empty = (rem_ff == 3'd0);
   assign move      = !buf_empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (group.valid) begin
            rem_ff <= group.count;
         end else if (move) begin
            rem_ff <= rem_ff - 3'd1;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (group.valid) begin
         data_ff <= group.data;
         last_ff <= group.last;
         bad_ff  <= group.bad;
      end else if (move) begin
         data_ff <= {8'h00, data_ff[b64sc_pkg::GroupChars-1:1]};
      end
      if (move) begin
         rsp_data_ff.out_byte <= data_ff[0];
         rsp_data_ff.out_last <= last_ff && (rem_ff == 3'd1);
         rsp_data_ff.bad_char <= bad_ff;
      end
   end

   a_load_when_empty: assert property (@(posedge clock) disable iff (reset)
      group.valid |-> rem_ff == 3'd0)
      else $error("group loaded while buffer still holds items");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      !(rem_ff > 3'(b64sc_pkg::GroupChars)))
      else $error("buffer count out of range");

endmodule

### rtl/base64_stream_codec.sv
// top level of the streaming base64 encoder and decoder
// Encodes bytes to base64 text (direction 0) or decodes text to bytes (direction 1),
// one item in and at most one item out per cycle. An accepted item sits in an input
// register; the item that completes a group (three bytes, four characters, or in_last)
// loads a four-entry buffer that sends one result item per cycle through the output
// register while rsp_ready allows, so the first result passes from the input register
// through the buffer to the output register. The output side sets the rate: a
// group-closing item waits in the input register until the buffer has drained, and the
// buffer reloads only after its last item has left. Encoding gives four characters per
// group, and items that do not close a group are still taken while the buffer drains.
// Decoding takes one character per cycle when the output keeps up. Writing the direction
// register clears any partial group.
module base64_stream_codec (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  b64sc_pkg::req_payload_type          req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output b64sc_pkg::rsp_payload_type          rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [b64sc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   b64sc_pkg::cfg_type    cfg;
   b64sc_pkg::group_type  group;
   logic                  buf_empty;

   b64sc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   b64sc_group u_group (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .buf_empty (buf_empty),
      .group     (group)
   );

   b64sc_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .group     (group),
      .buf_empty (buf_empty),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
